// ----- rtl/rle_pkg.sv -----
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants, types and the controller/datapath interface structs for
// the run-length encoder.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned NUM_DIG = 5;
  localparam int unsigned NDIG_W  = 3;

  // Requested run bound; the bound in effect is limited to 3..65535.
  localparam longint unsigned MAX_RUN = 64'd65535;
  localparam logic [CNT_W:0] RUN_BOUND =
      (CNT_W+1)'((MAX_RUN < 64'd3) ? 64'd3 : ((MAX_RUN > 64'd65535) ? 64'd65535 : MAX_RUN));

  // x / 10 == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [CNT_W:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned    DIV10_SHIFT = 19;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    SEL_DIGIT,
    SEL_RUN,
    SEL_NEW
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     conv_step;
    logic     push;
    out_sel_t sel;
    logic     push_last;
  } rle_cmd_t;

  typedef struct packed {
    logic dec_any;
    logic has_emit;
    logic cnt_ge3;
    logic cnt_two;
    logic has_extra;
    logic conv_done;
    logic dig_done;
    logic can_push;
  } rle_stat_t;

endpackage

// ----- rtl/rle_ctrl.sv -----
// ----------------------------------------------------------------------------
// rle_ctrl
// Sequencer for the run-length encoder: accepts an item, runs the decimal
// conversion and steps through the result bytes of a closed run.
// ----------------------------------------------------------------------------
module rle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rle_pkg::rle_stat_t stat,
  output rle_pkg::rle_cmd_t  cmd
);
  import rle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_CONV,
    S_DIG,
    S_VAL1,
    S_VAL,
    S_XTRA
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.push      = 1'b0;
    cmd.sel       = SEL_RUN;
    cmd.push_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.dec_any) begin
            state_next = S_DISP;
          end
        end
      end
      S_DISP: begin
        if (stat.has_emit) begin
          if (stat.cnt_ge3) begin
            state_next = S_CONV;
          end else if (stat.cnt_two) begin
            state_next = S_VAL1;
          end else begin
            state_next = S_VAL;
          end
        end else begin
          state_next = S_XTRA;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_done) begin
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        if (stat.can_push) begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_DIGIT;
          if (stat.dig_done) begin
            state_next = S_VAL;
          end
        end
      end
      S_VAL1: begin
        if (stat.can_push) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_RUN;
          state_next = S_VAL;
        end
      end
      S_VAL: begin
        if (stat.can_push) begin
          cmd.push      = 1'b1;
          cmd.sel       = SEL_RUN;
          cmd.push_last = !stat.has_extra;
          state_next    = stat.has_extra ? S_XTRA : S_IDLE;
        end
      end
      S_XTRA: begin
        if (stat.can_push) begin
          cmd.push      = 1'b1;
          cmd.sel       = SEL_NEW;
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rle_dp.sv -----
// ----------------------------------------------------------------------------
// rle_dp
// Datapath of the run-length encoder: run state, the closed-run snapshot,
// the divide-by-ten digit unit and the output register.
// ----------------------------------------------------------------------------
module rle_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rle_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        stream_last,
  input  rle_pkg::rle_cmd_t           cmd,
  output rle_pkg::rle_stat_t          stat,
  output logic [rle_pkg::BYTE_W-1:0]  out_byte,
  output logic                        item_last,
  output logic                        stream_end,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import rle_pkg::*;

  logic [BYTE_W-1:0] run_value;
  logic [CNT_W-1:0]  run_count;
  logic [CNT_W-1:0]  run_count_next;
  logic [BYTE_W-1:0] e_val;
  logic [CNT_W-1:0]  e_cnt;
  logic [CNT_W-1:0]  work;
  logic [NDIG_W-1:0] ndig;
  logic [DIG_W-1:0]  digits [NUM_DIG];
  logic              has_emit;
  logic              has_extra;
  logic              is_last;

  logic              same;
  logic [CNT_W:0]    c_inc;
  logic              hit;
  logic              dec_emit;
  logic              dec_extra;
  logic [CNT_W-1:0]  chosen;

  logic [2*CNT_W:0]  prod;
  logic [CNT_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [NDIG_W-1:0] rd_idx;
  logic [BYTE_W-1:0] out_mux;

  // Decision for the item on the input port, used in the accept cycle.
  assign same      = (run_count != '0) && (in_byte == run_value);
  assign c_inc     = {1'b0, run_count} + (CNT_W+1)'(1);
  assign hit       = same && (c_inc >= RUN_BOUND);
  assign dec_emit  = same ? (hit || stream_last) : (run_count != '0);
  assign dec_extra = !same && stream_last;
  assign chosen    = same ? c_inc[CNT_W-1:0] : run_count;

  always_comb begin
    if (same) begin
      run_count_next = (hit || stream_last) ? '0 : c_inc[CNT_W-1:0];
    end else begin
      run_count_next = stream_last ? '0 : CNT_W'(1);
    end
  end

  // One decimal digit per step, least significant first.
  assign prod = (2*CNT_W+1)'(work) * (2*CNT_W+1)'(DIV10_MUL);
  assign quot = prod[DIV10_SHIFT +: CNT_W];
  assign rem  = work - ((quot << 3) + (quot << 1));

  assign rd_idx = ndig - NDIG_W'(1);

  always_comb begin
    case (cmd.sel)
      SEL_DIGIT: out_mux = ASCII_ZERO + BYTE_W'(digits[rd_idx]);
      SEL_RUN:   out_mux = e_val;
      SEL_NEW:   out_mux = run_value;
      default:   out_mux = e_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value <= '0;
      run_count <= '0;
      has_emit  <= 1'b0;
      has_extra <= 1'b0;
      is_last   <= 1'b0;
      ndig      <= '0;
    end else begin
      if (cmd.load) begin
        run_count <= run_count_next;
        if (!same) begin
          run_value <= in_byte;
        end
        has_emit  <= dec_emit;
        has_extra <= dec_extra;
        is_last   <= stream_last;
        ndig      <= '0;
      end else if (cmd.conv_step) begin
        ndig <= ndig + NDIG_W'(1);
      end else if (cmd.push && (cmd.sel == SEL_DIGIT)) begin
        ndig <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_val <= run_value;
      e_cnt <= chosen;
      work  <= chosen;
    end else if (cmd.conv_step) begin
      digits[ndig] <= rem[DIG_W-1:0];
      work         <= quot;
    end
  end

  // Output register; a new byte may enter while the held one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte   <= out_mux;
      item_last  <= cmd.push_last;
      stream_end <= cmd.push_last && is_last;
    end
  end

  assign stat.dec_any   = dec_emit || dec_extra;
  assign stat.has_emit  = has_emit;
  assign stat.cnt_ge3   = (e_cnt >= CNT_W'(3));
  assign stat.cnt_two   = (e_cnt == CNT_W'(2));
  assign stat.has_extra = has_extra;
  assign stat.conv_done = (quot == '0);
  assign stat.dig_done  = (ndig == NDIG_W'(1));
  assign stat.can_push  = !out_valid || out_ready;

endmodule

// ----- rtl/run_length_encoder_core.sv -----
// ----------------------------------------------------------------------------
// run_length_encoder_core
// Run-length encoder with decimal run counts over a byte stream.
// ----------------------------------------------------------------------------
// A byte that only extends the open run is taken while the encoder stays idle
// and produces nothing. An item that closes a run passes the accept and
// dispatch states, then the divide-by-ten loop with one decimal digit per step
// (runs of three or more, up to five digits), then its result bytes, at most
// seven, paced by out_ready through the single output register. Runs of three
// or more come out as ASCII digits of the length, most significant first,
// then the byte; runs of two and one as the byte repeated. Runs close at
// 65535 bytes. item_last marks the last result of an item, stream_end the last
// result of the stream.
module run_length_encoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rle_pkg::BYTE_W-1:0] in_byte,
  input  logic                       stream_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rle_pkg::BYTE_W-1:0] out_byte,
  output logic                       item_last,
  output logic                       stream_end
);
  import rle_pkg::*;

  rle_cmd_t  cmd;
  rle_stat_t stat;

  rle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rle_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .stream_last (stream_last),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (out_byte),
    .item_last   (item_last),
    .stream_end  (stream_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule
